[hw/rtl/b64d_pkg.sv]
// Shared types, constants and the alphabet lookup of the base64 stream decoder.
package b64d_pkg;

    localparam int unsigned CharWidth   = 8;
    localparam int unsigned SextetWidth = 6;
    localparam int unsigned LengthWidth = 16;
    localparam int unsigned GroupBytes  = 3;

    // Lookup result code for a character outside the alphabet.
    localparam logic [SextetWidth:0] SEXTET_NONE = 7'd64;

    // Configuration register indexes.
    localparam logic [0:0] REG_MAX_OUTPUT_LENGTH = 1'b0;

    localparam logic [LengthWidth-1:0] MAX_OUTPUT_LENGTH_RESET = 16'd512;

    // Everything one input character produces: up to three bytes, the length
    // before the first of them and the end mark.
    typedef struct packed {
        logic [GroupBytes-1:0][CharWidth-1:0] bytes;
        logic [1:0]                           byte_count;
        logic [LengthWidth-1:0]               base_length;
        logic                                 last;
    } b64d_bundle_t;

    function automatic logic [SextetWidth:0] sextet_of(input logic [CharWidth-1:0] c);
        logic [CharWidth-1:0] v;
        v = 8'd0;
        if (c >= 8'd65 && c <= 8'd90) begin
            v = c - 8'd65;
        end else if (c >= 8'd97 && c <= 8'd122) begin
            v = c - 8'd71;
        end else if (c >= 8'd48 && c <= 8'd57) begin
            v = c + 8'd4;
        end else if (c == 8'd43) begin
            v = 8'd62;
        end else if (c == 8'd47) begin
            v = 8'd63;
        end else begin
            return SEXTET_NONE;
        end
        return {1'b0, v[SextetWidth-1:0]};
    endfunction

endpackage

[hw/rtl/b64d_front.sv]
// Front end: classifies characters, collects sextets and forms result bundles.
module b64d_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [7:0]                   text_char,
    input  logic                         last_char,
    input  logic [15:0]                  max_output_length,
    output logic                         bundle_push,
    output b64d_pkg::b64d_bundle_t       bundle
);
    import b64d_pkg::*;

    logic [SextetWidth-1:0] sextet_buffer_reg [GroupBytes];
    logic [SextetWidth-1:0] sextet_buffer_next [GroupBytes];
    logic [1:0]             sextet_count_reg, sextet_count_next;
    logic [LengthWidth-1:0] emitted_count_reg, emitted_count_next;

    logic [SextetWidth:0]   lookup;
    logic                   take;
    logic                   group_done;
    logic [1:0]             held;
    logic [1:0]             want;
    logic [1:0]             emit;
    logic [LengthWidth-1:0] room;
    logic [GroupBytes-1:0][CharWidth-1:0] group_bytes;

    assign lookup = sextet_of(text_char);
    assign take   = (lookup != SEXTET_NONE) && (emitted_count_reg < max_output_length);
    assign group_done = take && (sextet_count_reg == 2'd3);
    assign room = (max_output_length > emitted_count_reg) ?
                  (max_output_length - emitted_count_reg) : '0;

    always_comb
    begin
        sextet_buffer_next = sextet_buffer_reg;
        held = sextet_count_reg;
        if (take && !group_done)
        begin
            sextet_buffer_next[sextet_count_reg] = lookup[SextetWidth-1:0];
            held = sextet_count_reg + 2'd1;
        end
        group_bytes[0] = {sextet_buffer_next[0], sextet_buffer_next[1][5:4]};
        group_bytes[1] = {sextet_buffer_next[1][3:0], sextet_buffer_next[2][5:2]};
        group_bytes[2] = {sextet_buffer_next[2][1:0], lookup[SextetWidth-1:0]};
        if (group_done)
        begin
            want = 2'd3;
        end
        else if (last_char && held >= 2'd2)
        begin
            // A pending pair gives one tail byte, a pending triple two.
            want = held - 2'd1;
        end
        else
        begin
            want = 2'd0;
        end
        emit = (room < {14'd0, want}) ? room[1:0] : want;
    end

    assign bundle.bytes       = group_bytes;
    assign bundle.byte_count  = emit;
    assign bundle.base_length = emitted_count_reg;
    assign bundle.last        = last_char;
    assign bundle_push = accept && ((emit != 2'd0) || last_char);

    always_comb
    begin
        if (last_char || group_done)
        begin
            sextet_count_next = 2'd0;
        end
        else
        begin
            sextet_count_next = held;
        end
        emitted_count_next = last_char ? '0 : (emitted_count_reg + {14'd0, emit});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sextet_count_reg  <= 2'd0;
            emitted_count_reg <= '0;
        end
        else if (accept)
        begin
            sextet_count_reg  <= sextet_count_next;
            emitted_count_reg <= emitted_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sextet_buffer_reg <= sextet_buffer_next;
        end
    end

endmodule

[hw/rtl/b64d_queue.sv]
// Short queue of result bundles between the front end and the back end.
module b64d_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  b64d_pkg::b64d_bundle_t push_data,
    output logic                   full,
    input  logic                   pop,
    output b64d_pkg::b64d_bundle_t pop_data,
    output logic                   empty
);
    import b64d_pkg::*;

    localparam int unsigned PtrWidth = $clog2(DEPTH);
    localparam int unsigned CntWidth = $clog2(DEPTH + 1);
    localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
    localparam logic [CntWidth-1:0] FullCount = CntWidth'(DEPTH);

    b64d_bundle_t        mem [DEPTH];
    logic [PtrWidth-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrWidth-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntWidth-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign full     = (count_reg == FullCount);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hw/rtl/b64d_back.sv]
// Back end: unpacks queued bundles into one result beat per pop.
module b64d_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  b64d_pkg::b64d_bundle_t q_data,
    input  logic                   q_empty,
    output logic                   q_pop,
    input  logic                   pop,
    output logic                   empty,
    output logic [7:0]             data_byte,
    output logic                   byte_valid,
    output logic                   end_of_message,
    output logic [15:0]            decoded_length
);
    import b64d_pkg::*;

    b64d_bundle_t cur_reg;
    logic         cur_valid_reg;
    logic [1:0]   idx_reg;
    logic [1:0]   last_idx;
    logic         advance;
    logic         finishing;

    assign last_idx  = (cur_reg.byte_count == 2'd0) ? 2'd0 : cur_reg.byte_count - 2'd1;
    assign advance   = pop && cur_valid_reg;
    assign finishing = !cur_valid_reg || (advance && idx_reg == last_idx);
    assign q_pop     = finishing && !q_empty;

    assign empty          = !cur_valid_reg;
    assign byte_valid     = (cur_reg.byte_count != 2'd0);
    assign data_byte      = byte_valid ? cur_reg.bytes[idx_reg] : 8'd0;
    assign end_of_message = cur_reg.last && (idx_reg == last_idx);
    // Each beat reports the count including its own byte.
    assign decoded_length = byte_valid ?
                            (cur_reg.base_length + {14'd0, idx_reg} + 16'd1) :
                            cur_reg.base_length;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else if (q_pop)
        begin
            cur_valid_reg <= 1'b1;
            idx_reg       <= 2'd0;
        end
        else if (finishing)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else if (advance)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
    end

endmodule

[hw/rtl/base64_stream_decoder.sv]
// Top level of the base64 stream decoder with its configuration port.
// The decoder takes one character beat per clock cycle for as long as full is
// low; full rises only when all QUEUE_DEPTH entries of the internal bundle queue
// are occupied. A character completing a group of four sextets queues up to
// three byte beats, a last character queues its tail bytes or a single end
// beat, and other characters queue nothing. The back end drains one result
// beat per pop, so a message yields results at one beat per cycle while beats
// wait and pop is held; input stalls only when the consumer falls behind by
// more than the queue holds. The limit register max_output_length (byte
// address 0, reset 512) should be written only while the decoder is idle.
module base64_stream_decoder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  text_char,
    input  logic        last_char,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  data_byte,
    output logic        byte_valid,
    output logic        end_of_message,
    output logic [15:0] decoded_length
);
    import b64d_pkg::*;

    logic [LengthWidth-1:0] max_output_length_reg;
    logic                   cfg_write;
    logic                   accept;
    logic                   bundle_push;
    b64d_bundle_t           bundle;
    b64d_bundle_t           q_data;
    logic                   q_empty;
    logic                   q_pop;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_MAX_OUTPUT_LENGTH) ?
                       {16'd0, max_output_length_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_output_length_reg <= MAX_OUTPUT_LENGTH_RESET;
        end
        else if (cfg_write && paddr[2] == REG_MAX_OUTPUT_LENGTH)
        begin
            max_output_length_reg <= pwdata[LengthWidth-1:0];
        end
    end

    assign accept = push && !full;

    b64d_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (accept),
        .text_char         (text_char),
        .last_char         (last_char),
        .max_output_length (max_output_length_reg),
        .bundle_push       (bundle_push),
        .bundle            (bundle)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (bundle_push),
        .push_data (bundle),
        .full      (full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    b64d_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_data         (q_data),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .pop            (pop),
        .empty          (empty),
        .data_byte      (data_byte),
        .byte_valid     (byte_valid),
        .end_of_message (end_of_message),
        .decoded_length (decoded_length)
    );

endmodule
